FILE: hdl/kmer_intern_hash_table_unit_defines.svh
// assertion macros shared by the k-mer interning unit
`ifndef KMER_INTERN_HASH_TABLE_UNIT_DEFINES_SVH
`define KMER_INTERN_HASH_TABLE_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define KIHT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// same-cycle implication outside reset
`define KIHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication outside reset
`define KIHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/kiht_pkg.sv
// ----------------------------------------------------------------------------
// kiht_pkg
// shared constants, types and the fnv-1a step for the k-mer interning unit
// ----------------------------------------------------------------------------
package kiht_pkg;

   localparam int MAX_KMER_DEF    = 16;
   localparam int ID_LIMIT_DEF    = 1024;
   localparam int TABLE_SLOTS_DEF = 2048;

   localparam int KMER_ID_W   = 10;
   localparam int COUNT_W     = 11;
   localparam int KLEN_W      = 5;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd8;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   // prime is 2^40 + 2^8 + 0xb3
   localparam logic [7:0]  FNV_PRIME_LOW = 8'hB3;

   localparam logic FUNC_PUSH    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_KEY_CHK,
      ST_RESULT
   } back_state_type;

   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x * {56'd0, FNV_PRIME_LOW});
   endfunction

endpackage

FILE: hdl/kiht_ram.sv
// ----------------------------------------------------------------------------
// kiht_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kiht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/kiht_fifo.sv
// ----------------------------------------------------------------------------
// kiht_fifo
// short word queue between the front and the back
// ----------------------------------------------------------------------------
module kiht_fifo
   import kiht_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/kiht_front.sv
// ----------------------------------------------------------------------------
// kiht_front
// accepts words, keeps the byte window and the length register, and queues
// restarts and complete k-mers for the back
// ----------------------------------------------------------------------------
module kiht_front
   import kiht_pkg::*;
#(
   parameter int MAX_KMER = MAX_KMER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [BYTE_W-1:0]     req_base_byte,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [KLEN_W-1:0]     csr_data,
   input  logic                  hold,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [MAX_KMER*BYTE_W+$clog2(MAX_KMER+1):0] q_data
);

   localparam int KB  = MAX_KMER * BYTE_W;
   localparam int KLW = $clog2(MAX_KMER + 1);

   logic [KB-1:0]         win_ff, win_in;
   logic [KLW-1:0]        fill_ff, fill_in;
   logic [KLEN_W-1:0]     klen_ff;
   logic [KLW-1:0]        keff;
   logic [KB-1:0]         kmer;
   logic                  accept;

   assign csr_ready = 1'b1;
   assign req_full  = q_full || hold;
   assign accept    = req_push && !req_full;

   // effective length: zero acts as one, too large saturates
   always_comb begin
      if (klen_ff == '0) begin
         keff = KLW'(1);
      end else if ({1'b0, klen_ff} > (KLEN_W+1)'(MAX_KMER)) begin
         keff = KLW'(MAX_KMER);
      end else begin
         keff = KLW'(klen_ff);
      end
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (req_func == FUNC_RESTART) begin
            win_in  = '0;
            fill_in = '0;
         end else begin
            for (int i = 0; i < MAX_KMER - 1; i++) begin
               win_in[i*BYTE_W +: BYTE_W] = win_ff[(i+1)*BYTE_W +: BYTE_W];
            end
            win_in[(MAX_KMER-1)*BYTE_W +: BYTE_W] = req_base_byte;
            if (fill_ff != KLW'(MAX_KMER)) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end
   end

   // last keff bytes, oldest first, zero fill beyond
   always_comb begin
      int src;
      kmer = '0;
      for (int j = 0; j < MAX_KMER; j++) begin
         src = MAX_KMER - int'(keff) + j;
         if (j < int'(keff)) begin
            kmer[j*BYTE_W +: BYTE_W] = win_in[src*BYTE_W +: BYTE_W];
         end
      end
   end

   always_comb begin
      q_push = 1'b0;
      q_data = {req_func, keff, kmer};
      if (accept) begin
         if (req_func == FUNC_RESTART) begin
            q_push = 1'b1;
         end else if (fill_in >= keff) begin
            q_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
         klen_ff <= KLEN_RESET;
      end else begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
         if (csr_valid && csr_ready) begin
            klen_ff <= csr_data;
         end
      end
   end

endmodule

FILE: hdl/kiht_back.sv
// ----------------------------------------------------------------------------
// kiht_back
// hashes queued k-mers, probes the slot table, inserts, holds the result and clears the table on reset and restart
// ----------------------------------------------------------------------------
module kiht_back
   import kiht_pkg::*;
#(
   parameter int MAX_KMER    = MAX_KMER_DEF,
   parameter int ID_LIMIT    = ID_LIMIT_DEF,
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic [MAX_KMER*BYTE_W+$clog2(MAX_KMER+1):0] q_data,
   output logic                 clearing,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [KMER_ID_W-1:0] rsp_kmer_id,
   output logic                 rsp_is_new,
   output logic                 rsp_table_full,
   output logic [COUNT_W-1:0]   rsp_unique_count
);

   localparam int KB   = MAX_KMER * BYTE_W;
   localparam int KLW  = $clog2(MAX_KMER + 1);
   localparam int JW   = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
   localparam int SW   = $clog2(TABLE_SLOTS);
   localparam int IDW  = $clog2(ID_LIMIT);
   localparam int CNTW = $clog2(ID_LIMIT + 1);

   back_state_type state_ff, state_in;

   logic [KB-1:0]   kmer_ff, kmer_in;
   logic [KLW-1:0]  k_ff, k_in;
   logic [KLW-1:0]  j_ff, j_in;
   logic [63:0]     h_ff, h_in, h_step;
   logic [SW-1:0]   idx_ff, idx_in;
   logic [SW:0]     probe_ff, probe_in;
   logic [CNTW-1:0] sval_ff, sval_in;
   logic [CNTW-1:0] next_free_ff, next_free_in;
   logic [SW-1:0]   clr_ff, clr_in;

   logic [IDW-1:0]  res_id_ff, res_id_in;
   logic            res_new_ff, res_new_in;
   logic            res_full_ff, res_full_in;

   logic            out_valid_ff, out_valid_in;
   logic [IDW-1:0]  out_id_ff, out_id_in;
   logic            out_new_ff, out_new_in;
   logic            out_full_ff, out_full_in;
   logic [CNTW-1:0] out_cnt_ff, out_cnt_in;

   logic            slot_we;
   logic [SW-1:0]   slot_waddr;
   logic [CNTW-1:0] slot_wdata, slot_rdata;
   logic            store_we;
   logic [KB-1:0]   store_rdata, kmask;
   logic [IDW-1:0]  store_raddr;

   logic            q_restart;
   logic [KLW-1:0]  q_k;
   logic [KB-1:0]   q_kmer;
   logic            s_live, key_match, last_probe, hash_last, out_free;

   assign {q_restart, q_k, q_kmer} = q_data;

   kiht_ram #(.WIDTH(CNTW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_waddr),
      .wr_data(slot_wdata),
      .rd_addr(idx_ff),
      .rd_data(slot_rdata)
   );

   kiht_ram #(.WIDTH(KB), .DEPTH(ID_LIMIT)) u_store_ram (
      .clock  (clock),
      .wr_en  (store_we),
      .wr_addr(IDW'(next_free_ff)),
      .wr_data(kmer_ff),
      .rd_addr(store_raddr),
      .rd_data(store_rdata)
   );

   always_comb begin
      kmask = '0;
      for (int j = 0; j < MAX_KMER; j++) begin
         if (j < int'(k_ff)) begin
            kmask[j*BYTE_W +: BYTE_W] = '1;
         end
      end
   end

   assign h_step      = fnv_step(h_ff, kmer_ff[j_ff[JW-1:0]*BYTE_W +: BYTE_W]);
   assign hash_last   = (j_ff == k_ff - 1'b1);
   assign store_raddr = IDW'(slot_rdata - 1'b1);
   // stale slot values past the id counter never match
   assign s_live      = (slot_rdata - 1'b1) < next_free_ff;
   assign key_match   = (((store_rdata ^ kmer_ff) & kmask) == '0);
   assign last_probe  = (probe_ff == (SW+1)'(TABLE_SLOTS - 1));
   assign out_free    = !out_valid_ff || rsp_pop;
   assign clearing    = (state_ff == ST_CLEAR);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SW'(TABLE_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_empty) state_in = q_restart ? ST_CLEAR : ST_HASH;
         end
         ST_HASH: begin
            if (hash_last) state_in = ST_SLOT_RD;
         end
         ST_SLOT_RD: state_in = ST_SLOT_CHK;
         ST_SLOT_CHK: begin
            if (slot_rdata == '0) begin
               state_in = ST_RESULT;
            end else if (s_live) begin
               state_in = ST_KEY_CHK;
            end else begin
               state_in = last_probe ? ST_RESULT : ST_SLOT_RD;
            end
         end
         ST_KEY_CHK: begin
            if (key_match || last_probe) state_in = ST_RESULT;
            else state_in = ST_SLOT_RD;
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kmer_in      = kmer_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      h_in         = h_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      sval_in      = sval_ff;
      next_free_in = next_free_ff;
      clr_in       = clr_ff;
      res_id_in    = res_id_ff;
      res_new_in   = res_new_ff;
      res_full_in  = res_full_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_id_in    = out_id_ff;
      out_new_in   = out_new_ff;
      out_full_in  = out_full_ff;
      out_cnt_in   = out_cnt_ff;
      q_pop        = 1'b0;
      slot_we      = 1'b0;
      slot_waddr   = idx_ff;
      slot_wdata   = next_free_ff + 1'b1;
      store_we     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_restart) begin
                  clr_in       = '0;
                  next_free_in = '0;
               end else begin
                  kmer_in = q_kmer;
                  k_in    = q_k;
                  j_in    = '0;
                  h_in    = FNV_BASIS;
               end
            end
         end
         ST_HASH: begin
            h_in = h_step;
            j_in = j_ff + 1'b1;
            if (hash_last) begin
               idx_in   = h_step[SW-1:0];
               probe_in = '0;
            end
         end
         ST_SLOT_RD: begin
         end
         ST_SLOT_CHK: begin
            sval_in = slot_rdata;
            if (slot_rdata == '0) begin
               if (next_free_ff < CNTW'(ID_LIMIT)) begin
                  slot_we      = 1'b1;
                  store_we     = 1'b1;
                  res_id_in    = IDW'(next_free_ff);
                  res_new_in   = 1'b1;
                  res_full_in  = 1'b0;
                  next_free_in = next_free_ff + 1'b1;
               end else begin
                  res_id_in   = '0;
                  res_new_in  = 1'b0;
                  res_full_in = 1'b1;
               end
            end else if (!s_live) begin
               idx_in   = idx_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               res_id_in   = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
            end
         end
         ST_KEY_CHK: begin
            if (key_match) begin
               res_id_in   = IDW'(sval_ff - 1'b1);
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
            end else begin
               idx_in      = idx_ff + 1'b1;
               probe_in    = probe_ff + 1'b1;
               res_id_in   = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_id_in    = res_id_ff;
               out_new_in   = res_new_ff;
               out_full_in  = res_full_ff;
               out_cnt_in   = next_free_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         out_valid_ff <= out_valid_in;
      end
      kmer_ff     <= kmer_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      h_ff        <= h_in;
      idx_ff      <= idx_in;
      probe_ff    <= probe_in;
      sval_ff     <= sval_in;
      res_id_ff   <= res_id_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      out_id_ff   <= out_id_in;
      out_new_ff  <= out_new_in;
      out_full_ff <= out_full_in;
      out_cnt_ff  <= out_cnt_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_kmer_id      = KMER_ID_W'(out_id_ff);
   assign rsp_is_new       = out_new_ff;
   assign rsp_table_full   = out_full_ff;
   assign rsp_unique_count = COUNT_W'(out_cnt_ff);

endmodule

FILE: hdl/kmer_intern_hash_table_unit.sv
// ----------------------------------------------------------------------------
// kmer_intern_hash_table_unit
// interns k-mers of a byte stream into dense ids over an fnv-1a hash table
// ----------------------------------------------------------------------------
// usage:
//   req_ channel is queue-like: a word (func, base_byte) is taken when
//   req_push is high and req_full low. func restart clears window and table.
//   rsp_ channel: a result waits on the rsp_ ports while rsp_empty is low and
//   is taken when rsp_pop is high. a byte yields a result only once the
//   window holds kmer_length bytes; a restart yields none.
//   csr_ channel writes kmer_length (csr_ready is always high).
// timing:
//   the front takes a word per cycle into a two-word queue while req_full is
//   low. the back pops the queue, hashes the k-mer with one 64-bit fnv step
//   per cycle, then reads and checks each probed slot, compares the stored key
//   on a live slot, and loads the output register from the result.
// reset and stalls:
//   after reset and after each restart the back clears the slot table, one
//   slot per cycle; req_full stays high meanwhile.
//   a held result stalls the back; the queue keeps the front going.
// ----------------------------------------------------------------------------
`include "kmer_intern_hash_table_unit_defines.svh"

module kmer_intern_hash_table_unit
   import kiht_pkg::*;
#(
   parameter int MAX_KMER    = MAX_KMER_DEF,
   parameter int ID_LIMIT    = ID_LIMIT_DEF,
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [BYTE_W-1:0]     req_base_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [KMER_ID_W-1:0]  rsp_kmer_id,
   output logic                  rsp_is_new,
   output logic                  rsp_table_full,
   output logic [COUNT_W-1:0]    rsp_unique_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [KLEN_W-1:0]     csr_data
);

   localparam int QW = MAX_KMER * BYTE_W + $clog2(MAX_KMER + 1) + 1;

   logic          q_push, q_full, q_pop, q_empty, clearing;
   logic [QW-1:0] q_wdata, q_rdata;

   kiht_front #(.MAX_KMER(MAX_KMER)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_base_byte(req_base_byte),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .hold         (clearing),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   kiht_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .empty    (q_empty)
   );

   kiht_back #(
      .MAX_KMER   (MAX_KMER),
      .ID_LIMIT   (ID_LIMIT),
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_data          (q_rdata),
      .clearing        (clearing),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kmer_id     (rsp_kmer_id),
      .rsp_is_new      (rsp_is_new),
      .rsp_table_full  (rsp_table_full),
      .rsp_unique_count(rsp_unique_count)
   );

   `KIHT_ASSERT_NEVER(a_new_and_full, clock, reset, !rsp_empty && rsp_is_new && rsp_table_full, "result both new and full")
   `KIHT_ASSERT_IMPL(a_full_id_zero, clock, reset, !rsp_empty && rsp_table_full, rsp_kmer_id == '0, "full result with nonzero id")
   `KIHT_ASSERT_IMPL(a_new_id_count, clock, reset, !rsp_empty && rsp_is_new, rsp_kmer_id == KMER_ID_W'(rsp_unique_count - 1'b1), "new id does not match count")
   `KIHT_ASSERT_NEXT(a_clear_blocks, clock, reset, clearing && q_empty, !q_pop, "queue popped during clear")

endmodule

FILE: tb/sv/kmer_intern_hash_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmer_intern_hash_table_unit_tb
// drives byte streams and restarts through the k-mer interning unit, predicts
// ids, new flags, full flags and counts with its own fnv-1a table, and checks
// every result word in order under random idling on both sides
// ----------------------------------------------------------------------------
module kmer_intern_hash_table_unit_tb
   import kiht_pkg::*;
;

   localparam int WIN     = MAX_KMER_DEF;
   localparam int IDS     = ID_LIMIT_DEF;
   localparam int SLOTS   = TABLE_SLOTS_DEF;
   localparam int SETTLE  = SLOTS + 200;

   typedef struct {
      logic [KMER_ID_W-1:0] kmer_id;
      logic                 is_new;
      logic                 table_full;
      logic [COUNT_W-1:0]   unique_count;
   } intern_result_type;

   class kmer_scoreboard;
      logic [7:0]         window[WIN];
      int                 fill;
      int                 slot_of[SLOTS];
      logic [7:0]         kmer_bytes[IDS][WIN];
      int                 next_id;
      logic [KLEN_W-1:0]  length_reg;
      intern_result_type  expected_q[$];
      int                 errors;

      function new();
         length_reg = KLEN_RESET;
         errors = 0;
         clear_table();
      endfunction

      function void clear_table();
         foreach (window[i]) window[i] = 8'd0;
         foreach (slot_of[i]) slot_of[i] = 0;
         fill = 0;
         next_id = 0;
      endfunction

      function int eff_len();
         if (length_reg == 0) return 1;
         if (length_reg > WIN) return WIN;
         return int'(length_reg);
      endfunction

      function void note_input(logic func, logic [7:0] b);
         int k, idx, s;
         bit hit, empty, same;
         logic [63:0] h;
         intern_result_type r;
         if (func == FUNC_RESTART) begin
            clear_table();
            return;
         end
         for (int i = 0; i < WIN - 1; i++) window[i] = window[i+1];
         window[WIN-1] = b;
         if (fill < WIN) fill++;
         k = eff_len();
         if (fill < k) return;
         h = FNV_BASIS;
         for (int j = WIN - k; j < WIN; j++)
            h = (h ^ {56'd0, window[j]}) * 64'd1099511628211;
         idx = int'(h % SLOTS);
         hit = 0;
         empty = 0;
         r = '{default: '0};
         for (int p = 0; p < SLOTS; p++) begin
            s = slot_of[idx];
            if (s == 0) begin
               empty = 1;
               break;
            end
            if (s - 1 < next_id) begin
               same = 1;
               for (int j = 0; j < k; j++)
                  if (kmer_bytes[s-1][j] != window[WIN-k+j]) same = 0;
               if (same) begin
                  hit = 1;
                  r.kmer_id = KMER_ID_W'(s - 1);
                  break;
               end
            end
            idx = (idx + 1) % SLOTS;
         end
         if (!hit) begin
            if (empty && next_id < IDS) begin
               for (int j = 0; j < WIN; j++)
                  kmer_bytes[next_id][j] = (j < k) ? window[WIN-k+j] : 8'd0;
               slot_of[idx] = next_id + 1;
               r.kmer_id = KMER_ID_W'(next_id);
               r.is_new = 1'b1;
               next_id++;
            end else begin
               r.table_full = 1'b1;
            end
         end
         r.unique_count = COUNT_W'(next_id);
         expected_q.push_back(r);
      endfunction

      function void check_result(intern_result_type got);
         intern_result_type w;
         if (expected_q.size() == 0) begin
            $error("result word with none expected: id %0d", got.kmer_id);
            errors++;
            return;
         end
         w = expected_q.pop_front();
         if (got.kmer_id != w.kmer_id) begin
            $error("kmer_id expected %0d got %0d", w.kmer_id, got.kmer_id);
            errors++;
         end
         if (got.is_new != w.is_new) begin
            $error("is_new expected %0d got %0d", w.is_new, got.is_new);
            errors++;
         end
         if (got.table_full != w.table_full) begin
            $error("table_full expected %0d got %0d", w.table_full, got.table_full);
            errors++;
         end
         if (got.unique_count != w.unique_count) begin
            $error("unique_count expected %0d got %0d", w.unique_count, got.unique_count);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic                  req_func;
   logic [BYTE_W-1:0]     req_base_byte;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [KMER_ID_W-1:0]  rsp_kmer_id;
   logic                  rsp_is_new;
   logic                  rsp_table_full;
   logic [COUNT_W-1:0]    rsp_unique_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [KLEN_W-1:0]     csr_data;

   kmer_scoreboard sb;
   bit  no_idle;
   int  hold_request;

   kmer_intern_hash_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_base_byte    (req_base_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kmer_id      (rsp_kmer_id),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .rsp_unique_count (rsp_unique_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // mostly a four-letter alphabet so k-mers repeat and hit the table
   function automatic logic [7:0] pick_byte();
      logic [7:0] acgt[4];
      acgt = '{8'h41, 8'h43, 8'h47, 8'h54};
      if ($urandom_range(3) != 0) return acgt[$urandom_range(3)];
      return 8'($urandom_range(255));
   endfunction

   task automatic send_word(logic func, logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_func      <= func;
      req_base_byte <= b;
      do @(posedge clock); while (!(req_push && !req_full));
      sb.note_input(func, b);
   endtask

   task automatic drain();
      if (req_push) req_push <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // a restart or a dropped byte may still be in flight after the last result
   task automatic write_length(logic [KLEN_W-1:0] v);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.length_reg = v;
   endtask

   task automatic random_run(int n, bit allow_restart);
      for (int i = 0; i < n; i++) begin
         if (allow_restart && $urandom_range(79) == 0)
            send_word(FUNC_RESTART, 8'($urandom_range(255)));
         else send_word(FUNC_PUSH, pick_byte());
      end
   endtask

   // result side: random stalls, plus long holds asked for by the stimulus
   always @(posedge clock) begin
      int hold;
      intern_result_type got;
      if (reset) begin
         hold = 0;
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.kmer_id      = rsp_kmer_id;
            got.is_new       = rsp_is_new;
            got.table_full   = rsp_table_full;
            got.unique_count = rsp_unique_count;
            sb.check_result(got);
         end
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         if (hold == 0 && !no_idle) hold = pick_gap();
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      logic [KLEN_W-1:0] lens[8];
      sb = new();
      lens = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd12, 5'd2, 5'd8};
      no_idle       = 0;
      hold_request  = 0;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_func      = FUNC_PUSH;
      req_base_byte = 8'd0;
      rsp_pop       = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset length of 8: window fill, repeat hit, byte extremes, restart
      for (int i = 0; i < 10; i++) send_word(FUNC_PUSH, 8'h00);
      send_word(FUNC_PUSH, 8'hFF);
      send_word(FUNC_PUSH, 8'hAA);
      send_word(FUNC_RESTART, 8'hFF);
      send_word(FUNC_PUSH, 8'h55);
      write_length(5'd1);
      send_word(FUNC_PUSH, 8'h00);
      send_word(FUNC_PUSH, 8'hFF);
      send_word(FUNC_PUSH, 8'h00);
      send_word(FUNC_PUSH, 8'hFF);
      send_word(FUNC_RESTART, 8'h00);
      send_word(FUNC_PUSH, 8'h80);

      // sweep lengths with no restart at each change, so stored k-mers meet a new length
      foreach (lens[i]) begin
         write_length(lens[i]);
         no_idle = (i % 3 == 2);
         if (i == 4) begin
            hold_request = 400;
            random_run(40, 0);
            drain();
         end
         random_run(70, 1);
      end
      no_idle = 0;

      // two-byte k-mers over random bytes after a restart
      write_length(5'd2);
      send_word(FUNC_RESTART, 8'h00);
      for (int i = 0; i < 60; i++) send_word(FUNC_PUSH, 8'($urandom_range(255)));
      random_run(20, 0);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
